// ===== src/ac_frm_pkg.sv =====
// ============================================================================
// ac_frm_pkg: shared types and constants of the remote frame builder
// Request and result word layouts, operation and model codes, frame constants
// and the small code tables used when a frame is assembled.
// ============================================================================
package ac_frm_pkg;

    // Request word: one frame build request.
    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] item_index;
        logic [2:0] mode;
        logic [2:0] fan_speed;
        logic [7:0] setpoint;
        logic [5:0] feature_bits;
    } req_t;

    // Result word: one frame byte with its flags.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       rejected;
    } res_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODEL_SELECT = 2'd0;
    localparam logic [1:0] CFG_TEMP_FLOOR   = 2'd1;
    localparam logic [1:0] CFG_TEMP_CEILING = 2'd2;

    // Operation codes.
    localparam logic [1:0] OP_STATE  = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_EXTRA  = 2'd2;

    // Toggle indexes.
    localparam logic [2:0] TGL_POWER_OFF = 3'd0;
    localparam logic [2:0] TGL_POWERFUL  = 3'd2;
    localparam logic [2:0] TGL_ECONO     = 3'd3;
    localparam logic [2:0] TGL_LAST      = 3'd5;
    localparam logic [2:0] EXTRA_LAST    = 3'd3;

    // Mode codes of the request.
    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_COOL = 3'd1;
    localparam logic [2:0] MODE_LAST = 3'd5;

    // Remote model codes.
    localparam logic [2:0] MODEL_DEFAULT    = 3'd0;
    localparam logic [2:0] MODEL_MARKER_MAX = 3'd2;
    localparam logic [2:0] MODEL_ALT_TEMP   = 3'd3;
    localparam logic [2:0] MODEL_SHORT_A    = 3'd4;
    localparam logic [2:0] MODEL_SHORT_B    = 3'd5;
    localparam logic [2:0] MODEL_LAST       = 3'd5;

    // Frame byte constants.
    localparam logic [7:0] PRE_BYTE0     = 8'h14;
    localparam logic [7:0] PRE_BYTE1     = 8'h63;
    localparam logic [7:0] PRE_BYTE2     = 8'h00;
    localparam logic [7:0] PRE_BYTE3     = 8'h10;
    localparam logic [7:0] PRE_BYTE4     = 8'h10;
    localparam logic [7:0] LONG_MARK     = 8'hFE;
    localparam logic [7:0] PROTO_STD     = 8'h30;
    localparam logic [7:0] PROTO_ALT     = 8'h31;
    localparam logic [7:0] CKS_SHORT_FAM = 8'h9B;
    localparam logic [7:0] CMD_POWER_OFF = 8'h02;
    localparam logic [7:0] CMD_POWERFUL  = 8'h39;
    localparam logic [7:0] CMD_ECONO     = 8'h09;
    localparam logic [7:0] MARKER_BIT    = 8'h20;
    localparam logic [7:0] FILTER_BIT    = 8'h08;

    // Length of a full long frame.
    localparam int FRAME_BYTES = 16;

    // Short frame length for models with a complement byte.
    localparam int SHORT_BYTES = 7;
    localparam int REST_OFFSET = 7;

    // Sum of the fixed bytes 0..7 of a one-byte-shorter long frame (protocol 0x30).
    localparam int  FIXED_SUM_INT = 32'h14 + 32'h63 + 32'h00 + 32'h10 + 32'h10
                                  + 32'hFE + (FRAME_BYTES - 1 - REST_OFFSET) + 32'h30;
    localparam logic [7:0] FIXED_SUM15 = FIXED_SUM_INT[7:0];

    // Mode code of a long frame.
    function automatic logic [2:0] mode_code(input logic [2:0] m);
        logic [2:0] c;
        case (m)
            3'd0:    c = 3'h1;
            3'd1:    c = 3'h1;
            3'd2:    c = 3'h0;
            3'd3:    c = 3'h2;
            3'd4:    c = 3'h4;
            3'd5:    c = 3'h3;
            default: c = 3'h1;
        endcase
        return c;
    endfunction

    // Fan code of a long frame; unknown speeds act as auto.
    function automatic logic [2:0] fan_code(input logic [2:0] f);
        logic [2:0] c;
        case (f)
            3'd1:    c = 3'h3;
            3'd2:    c = 3'h2;
            3'd3:    c = 3'h1;
            default: c = 3'h0;
        endcase
        return c;
    endfunction

    // Command byte of an extra request.
    function automatic logic [7:0] extra_code(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0:    c = 8'h6C;
            2'd1:    c = 8'h6D;
            2'd2:    c = 8'h79;
            default: c = 8'h7A;
        endcase
        return c;
    endfunction

endpackage

// ===== src/ac_remote_frame_builder.sv =====
// ============================================================================
// ac_remote_frame_builder: air-conditioner remote frame builder
// Registers one request, assembles the whole frame in one pass into a frame
// register and sends it one byte per cycle while out_ready is high, flagging the last byte.
// ============================================================================
// The first byte of a frame is offered once its request has passed the input register and
// been loaded into the frame register. One frame byte per cycle while out_ready is high; a
// request gives 15 or 16 bytes for long frames, 6 or 7 for short ones, 1 when rejected, read
// from the frame register by the serialiser. The next request waits in the input register.
// Reset: asynchronous, active low; clears control flags and loads the configuration
// defaults (model 0, floor 16, ceiling 30). Frame bytes are not reset.
module ac_remote_frame_builder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ac_frm_pkg::req_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ac_frm_pkg::res_t  out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [5:0]        cfg_data
);

    localparam int FRAME_BYTES = ac_frm_pkg::FRAME_BYTES;
    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);

    // Configuration registers.
    logic [2:0] model_select_reg;
    logic [5:0] temp_floor_reg;
    logic [5:0] temp_ceiling_reg;

    // Input register.
    logic             in_valid_reg;
    ac_frm_pkg::req_t req_reg;

    // Frame register and serialiser state.
    logic [7:0]       frame_store_reg [FRAME_BYTES];
    logic [7:0]       frame_next      [FRAME_BYTES];
    logic [POS_W-1:0] byte_position_reg;
    logic [LEN_W-1:0] frame_length_reg;
    logic [LEN_W-1:0] frame_length_next;
    logic             sending_reg;
    logic             rejected_reg;
    logic             rejected_next;

    logic fire_out;
    logic is_last;
    logic done;
    logic load;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_select_reg <= 3'd0;
            temp_floor_reg   <= 6'd16;
            temp_ceiling_reg <= 6'd30;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ac_frm_pkg::CFG_MODEL_SELECT: model_select_reg <= cfg_data[2:0];
                ac_frm_pkg::CFG_TEMP_FLOOR:   temp_floor_reg   <= cfg_data;
                ac_frm_pkg::CFG_TEMP_CEILING: temp_ceiling_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Handshake control.
    assign fire_out  = out_valid && out_ready;
    assign is_last   = ((LEN_W'(byte_position_reg) + LEN_W'(1)) == frame_length_reg);
    assign done      = fire_out && is_last;
    assign load      = in_valid_reg && (!sending_reg || done);
    assign in_ready  = !in_valid_reg || load;
    assign out_valid = sending_reg;

    // Frame assembly from the registered request.
    always_comb
    begin
        logic [2:0] model;
        logic       short_fam;
        logic [7:0] floor8;
        logic [7:0] ceil8;
        logic [7:0] t_lo;
        logic [7:0] t_cl;
        logic [7:0] diff;
        logic [5:0] field;
        logic [2:0] long_mode;
        logic [7:0] b6;
        logic [7:0] b7;
        logic [7:0] b8;
        logic [7:0] b9;
        logic [7:0] b10;
        logic [7:0] b14;
        logic [7:0] sum16;
        logic [7:0] sum15;
        logic [7:0] cmd;
        logic       make_long;
        logic       bad;
        logic [LEN_W-1:0] llen;
        logic [LEN_W-1:0] slen;

        model = (model_select_reg > ac_frm_pkg::MODEL_LAST) ?
                ac_frm_pkg::MODEL_DEFAULT : model_select_reg;
        short_fam = (model == ac_frm_pkg::MODEL_SHORT_A) ||
                    (model == ac_frm_pkg::MODEL_SHORT_B);
        llen = short_fam ? LEN_W'(FRAME_BYTES - 1) : LEN_W'(FRAME_BYTES);
        slen = short_fam ? LEN_W'(ac_frm_pkg::SHORT_BYTES - 1) :
                           LEN_W'(ac_frm_pkg::SHORT_BYTES);

        // Clamp the setpoint: floor first, then the ceiling wins.
        floor8 = {2'b00, temp_floor_reg};
        ceil8  = {2'b00, temp_ceiling_reg};
        t_lo   = (req_reg.setpoint < floor8) ? floor8 : req_reg.setpoint;
        t_cl   = (t_lo > ceil8) ? ceil8 : t_lo;

        // Temperature field wraps to six bits.
        if (model == ac_frm_pkg::MODEL_ALT_TEMP)
        begin
            diff  = t_cl - {3'b000, temp_floor_reg[5:1]};
            field = {diff[4:0], 1'b0};
        end
        else
        begin
            diff  = t_cl - floor8;
            field = {diff[3:0], 2'b00};
        end

        long_mode = ((req_reg.mode == ac_frm_pkg::MODE_OFF) ||
                     (req_reg.mode > ac_frm_pkg::MODE_LAST)) ?
                    ac_frm_pkg::MODE_COOL : req_reg.mode;

        b6  = 8'(llen) - 8'(ac_frm_pkg::REST_OFFSET);
        b7  = (model == ac_frm_pkg::MODEL_ALT_TEMP) ?
              ac_frm_pkg::PROTO_ALT : ac_frm_pkg::PROTO_STD;
        b8  = {field, 2'b01};
        b9  = {4'h0, req_reg.feature_bits[5], ac_frm_pkg::mode_code(long_mode)};
        b10 = {3'b000, req_reg.feature_bits[1] && !short_fam, 1'b0,
               ac_frm_pkg::fan_code(req_reg.fan_speed)};
        b14 = ((model <= ac_frm_pkg::MODEL_MARKER_MAX) ? ac_frm_pkg::MARKER_BIT : 8'h00) |
              (req_reg.feature_bits[4] ? ac_frm_pkg::FILTER_BIT : 8'h00);

        // Checksums: bytes 7..14 negated, or 0x9B minus bytes 0..13.
        sum16 = b7 + b8 + b9 + b10 + b14;
        sum15 = ac_frm_pkg::FIXED_SUM15 + b8 + b9 + b10;

        // Request decode.
        bad       = 1'b0;
        make_long = 1'b0;
        cmd       = ac_frm_pkg::CMD_POWER_OFF;
        case (req_reg.operation)
            ac_frm_pkg::OP_STATE:
            begin
                bad = (req_reg.mode == ac_frm_pkg::MODE_OFF) ||
                      (req_reg.mode > ac_frm_pkg::MODE_LAST);
                make_long = 1'b1;
            end
            ac_frm_pkg::OP_TOGGLE:
            begin
                bad = (req_reg.item_index > ac_frm_pkg::TGL_LAST);
                case (req_reg.item_index)
                    ac_frm_pkg::TGL_POWER_OFF: cmd = ac_frm_pkg::CMD_POWER_OFF;
                    ac_frm_pkg::TGL_POWERFUL:  cmd = ac_frm_pkg::CMD_POWERFUL;
                    ac_frm_pkg::TGL_ECONO:     cmd = ac_frm_pkg::CMD_ECONO;
                    default:                   make_long = 1'b1;
                endcase
            end
            ac_frm_pkg::OP_EXTRA:
            begin
                bad = (req_reg.item_index > ac_frm_pkg::EXTRA_LAST);
                cmd = ac_frm_pkg::extra_code(req_reg.item_index[1:0]);
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        // Frame bytes; unused positions are cleared.
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame_next[i] = 8'h00;
        end
        frame_next[0] = ac_frm_pkg::PRE_BYTE0;
        frame_next[1] = ac_frm_pkg::PRE_BYTE1;
        frame_next[2] = ac_frm_pkg::PRE_BYTE2;
        frame_next[3] = ac_frm_pkg::PRE_BYTE3;
        frame_next[4] = ac_frm_pkg::PRE_BYTE4;

        if (bad)
        begin
            frame_next[0]     = 8'h00;
            frame_length_next = LEN_W'(1);
            rejected_next     = 1'b1;
        end
        else if (make_long)
        begin
            frame_next[5]  = ac_frm_pkg::LONG_MARK;
            frame_next[6]  = b6;
            frame_next[7]  = b7;
            frame_next[8]  = b8;
            frame_next[9]  = b9;
            frame_next[10] = b10;
            if (short_fam)
            begin
                frame_next[FRAME_BYTES-2] = ac_frm_pkg::CKS_SHORT_FAM - sum15;
            end
            else
            begin
                frame_next[FRAME_BYTES-2] = b14;
                frame_next[FRAME_BYTES-1] = 8'h00 - sum16;
            end
            frame_length_next = llen;
            rejected_next     = 1'b0;
        end
        else
        begin
            frame_next[5] = cmd;
            frame_next[6] = short_fam ? 8'h00 : ~cmd;
            frame_length_next = slen;
            rejected_next     = 1'b0;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
    end

    // Serialiser control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg       <= 1'b0;
            byte_position_reg <= '0;
            frame_length_reg  <= '0;
            rejected_reg      <= 1'b0;
        end
        else if (load)
        begin
            sending_reg       <= 1'b1;
            byte_position_reg <= '0;
            frame_length_reg  <= frame_length_next;
            rejected_reg      <= rejected_next;
        end
        else if (done)
        begin
            sending_reg       <= 1'b0;
            byte_position_reg <= '0;
        end
        else if (fire_out)
        begin
            byte_position_reg <= byte_position_reg + POS_W'(1);
        end
    end

    // Frame register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                frame_store_reg[i] <= frame_next[i];
            end
        end
    end

    // Result word.
    assign out_data.frame_byte = frame_store_reg[byte_position_reg];
    assign out_data.last_byte  = is_last;
    assign out_data.rejected   = rejected_reg;

    // A rejected request gives exactly one result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sending_reg && rejected_reg) |-> (frame_length_reg == LEN_W'(1) && is_last))
        else $error("rejected result is not a single last word");

    // The byte position never runs past the frame length.
    assert property (@(posedge clk) disable iff (!rst_n)
        sending_reg |-> (LEN_W'(byte_position_reg) < frame_length_reg))
        else $error("byte position beyond frame length");

    // Finishing a frame with nothing waiting leaves the serialiser idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_valid_reg) |=> !sending_reg)
        else $error("serialiser still busy after final byte");

    // Input is held back only while a request waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && sending_reg))
        else $error("input stalled without a waiting request");

    // A waiting request is handed over as soon as a frame completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_valid_reg) |=> (sending_reg && byte_position_reg == '0))
        else $error("waiting request not loaded after frame end");

endmodule
